// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Every check is clocked on the rising
// edge and is switched off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/lrb_pkg.sv -----
// ----------------------------------------------------------------------------
// lrb_pkg
// Types and constants shared by the link reconnect backoff controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrb_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX     = 2'd2;

    localparam logic [TIME_W-1:0] CONNECT_TIMEOUT_RESET = 32'd10000;
    localparam logic [TIME_W-1:0] BACKOFF_BASE_RESET    = 32'd1000;
    localparam logic [TIME_W-1:0] BACKOFF_MAX_RESET     = 32'd60000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [1:0] STATE_IDLE       = 2'd0;
    localparam logic [1:0] STATE_CONNECTING = 2'd1;
    localparam logic [1:0] STATE_CONNECTED  = 2'd2;
    localparam logic [1:0] STATE_BACKOFF    = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] connect_timeout_ms;
        logic [TIME_W-1:0] backoff_base_ms;
        logic [TIME_W-1:0] backoff_max_ms;
    } cfg_t;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
    } item_t;

    typedef struct packed {
        logic [1:0]         state_code;
        logic               connect_request;
        logic               disconnect_request;
        logic [COUNT_W-1:0] retry_count;
        logic [TIME_W-1:0]  current_backoff_ms;
    } result_t;

endpackage

// ----- rtl/lrb_cfg.sv -----
// ----------------------------------------------------------------------------
// lrb_cfg
// Configuration register file: timeout, base delay and maximum delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrb_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrb_pkg::TIME_W-1:0]    cfg_data,
    output lrb_pkg::cfg_t                 cfg
);

    lrb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.connect_timeout_ms <= lrb_pkg::CONNECT_TIMEOUT_RESET;
            cfg_reg.backoff_base_ms    <= lrb_pkg::BACKOFF_BASE_RESET;
            cfg_reg.backoff_max_ms     <= lrb_pkg::BACKOFF_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrb_pkg::REG_CONNECT_TIMEOUT: cfg_reg.connect_timeout_ms <= cfg_data;
                lrb_pkg::REG_BACKOFF_BASE:    cfg_reg.backoff_base_ms    <= cfg_data;
                lrb_pkg::REG_BACKOFF_MAX:     cfg_reg.backoff_max_ms     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/lrb_fsm.sv -----
// ----------------------------------------------------------------------------
// lrb_fsm
// Connection state machine. The state registers and the request pulses form
// the result register and advance once per request taken from the input stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrb_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lrb_pkg::item_t    item,
    input  lrb_pkg::cfg_t     cfg,
    output lrb_pkg::result_t  result
);

    typedef enum logic [1:0] {
        ST_IDLE       = lrb_pkg::STATE_IDLE,
        ST_CONNECTING = lrb_pkg::STATE_CONNECTING,
        ST_CONNECTED  = lrb_pkg::STATE_CONNECTED,
        ST_BACKOFF    = lrb_pkg::STATE_BACKOFF
    } state_t;

    state_t                       state_reg,   state_next;
    logic [lrb_pkg::TIME_W-1:0]   start_reg,   start_next;
    logic [lrb_pkg::TIME_W-1:0]   end_reg,     end_next;
    logic [lrb_pkg::TIME_W-1:0]   delay_reg,   delay_next;
    logic [lrb_pkg::COUNT_W-1:0]  count_reg,   count_next;
    logic                         creq_reg,    creq_next;
    logic                         dreq_reg,    dreq_next;

    logic [lrb_pkg::TIME_W-1:0]   elapsed;
    logic [lrb_pkg::TIME_W-1:0]   since_end;
    logic [lrb_pkg::TIME_W:0]     doubled;
    logic [lrb_pkg::TIME_W-1:0]   capped;
    logic                         timed_out;
    logic                         backoff_done;

    assign elapsed      = item.now_ms - start_reg;
    assign since_end    = item.now_ms - end_reg;
    assign timed_out    = elapsed > cfg.connect_timeout_ms;
    assign backoff_done = !since_end[lrb_pkg::TIME_W-1];
    assign doubled      = {delay_reg, 1'b0};
    assign capped       = (doubled > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
                                                                 : doubled[lrb_pkg::TIME_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        end_next   = end_reg;
        delay_next = delay_reg;
        count_next = count_reg;
        creq_next  = 1'b0;
        dreq_next  = 1'b0;

        if (item.command == lrb_pkg::CMD_START)
        begin
            state_next = ST_CONNECTING;
            start_next = item.now_ms;
            creq_next  = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_CONNECTING:
                begin
                    if (item.link_up)
                    begin
                        state_next = ST_CONNECTED;
                        delay_next = cfg.backoff_base_ms;
                        count_next = '0;
                    end
                    else if (timed_out)
                    begin
                        state_next = ST_BACKOFF;
                        end_next   = item.now_ms + delay_reg;
                        delay_next = capped;
                        dreq_next  = 1'b1;
                        if (count_reg != lrb_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                ST_CONNECTED:
                begin
                    if (!item.link_up)
                    begin
                        state_next = ST_CONNECTING;
                        start_next = item.now_ms;
                        creq_next  = 1'b1;
                    end
                end
                ST_BACKOFF:
                begin
                    if (backoff_done)
                    begin
                        state_next = ST_CONNECTING;
                        start_next = item.now_ms;
                        creq_next  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            end_reg   <= '0;
            delay_reg <= lrb_pkg::BACKOFF_BASE_RESET;
            count_reg <= '0;
            creq_reg  <= 1'b0;
            dreq_reg  <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            delay_reg <= delay_next;
            count_reg <= count_next;
            creq_reg  <= creq_next;
            dreq_reg  <= dreq_next;
        end
    end

    assign result.state_code         = state_reg;
    assign result.connect_request    = creq_reg;
    assign result.disconnect_request = dreq_reg;
    assign result.retry_count        = count_reg;
    assign result.current_backoff_ms = delay_reg;

endmodule

// ----- rtl/link_reconnect_backoff_fsm.sv -----
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm
// Link reconnection controller with exponential backoff.
//
// Requests arrive on the input channel (in_valid, in_stall): a start command
// or a poll carrying now_ms and link_up. Each request produces exactly one
// result on the output channel (out_valid, out_stall) with the new state,
// the connect and disconnect pulses, the retry count and the current delay.
// A request is registered in the input register at the edge it is accepted;
// its result is shown once the state update has loaded the result register.
// One request per cycle is sustained while the receiver does not stall: the
// next request is taken while the previous result is still being offered,
// since the state update sits between the input and result registers.
// When the receiver stalls, the result holds and the input register keeps
// one request; in_stall rises only when both are occupied.
// The configuration channel (cfg_valid, cfg_ready) is always ready and
// writes by register index. Reset clears both channels, sets the state to
// idle and loads the register defaults and the base delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_reconnect_backoff_fsm
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [lrb_pkg::TIME_W-1:0]     now_ms,
    input  logic                           link_up,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     state_code,
    output logic                           connect_request,
    output logic                           disconnect_request,
    output logic [lrb_pkg::COUNT_W-1:0]    retry_count,
    output logic [lrb_pkg::TIME_W-1:0]     current_backoff_ms,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrb_pkg::TIME_W-1:0]     cfg_data
);

    lrb_pkg::cfg_t    cfg;
    lrb_pkg::item_t   item_reg;
    lrb_pkg::result_t result;

    logic in_v_reg,  in_v_next;
    logic out_v_reg, out_v_next;
    logic out_free;
    logic advance;
    logic in_take;

    assign out_free = !out_v_reg || !out_stall;
    assign advance  = in_v_reg && out_free;
    assign in_stall = in_v_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_v_next  = in_take || (in_v_reg && !advance);
    assign out_v_next = advance || (out_v_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command <= command;
            item_reg.now_ms  <= now_ms;
            item_reg.link_up <= link_up;
        end
    end

    lrb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrb_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid          = out_v_reg;
    assign state_code         = result.state_code;
    assign connect_request    = result.connect_request;
    assign disconnect_request = result.disconnect_request;
    assign retry_count        = result.retry_count;
    assign current_backoff_ms = result.current_backoff_ms;

endmodule

// ----- rtl/lrb_checker.sv -----
// ----------------------------------------------------------------------------
// lrb_checker
// Port-level checks for the link reconnect backoff controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrb_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  state_code,
    input logic                        connect_request,
    input logic                        disconnect_request,
    input logic [lrb_pkg::COUNT_W-1:0] retry_count,
    input logic [lrb_pkg::TIME_W-1:0]  current_backoff_ms
);

    `ASSERT_NEXT_CYCLE(a_stall_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(state_code) && $stable(retry_count) && $stable(current_backoff_ms))

    `ASSERT_SAME_CYCLE(a_one_pulse, clk, rst_n, out_valid,
        !(connect_request && disconnect_request))

    `ASSERT_SAME_CYCLE(a_disc_backoff, clk, rst_n, out_valid && disconnect_request,
        state_code == lrb_pkg::STATE_BACKOFF && retry_count != '0)

    `ASSERT_SAME_CYCLE(a_conn_connecting, clk, rst_n, out_valid && connect_request,
        state_code == lrb_pkg::STATE_CONNECTING)

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .state_code         (state_code),
    .connect_request    (connect_request),
    .disconnect_request (disconnect_request),
    .retry_count        (retry_count),
    .current_backoff_ms (current_backoff_ms)
);

// ----- tb/link_backoff_checker.sv -----
// ----------------------------------------------------------------------------
// Link backoff checker
// Watches the request, result and register write channels of the link
// reconnect controller. It keeps its own copy of the connection state and the
// registers, and predicts one result for every accepted request. It then
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_backoff_checker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           command,
    input  logic [lrb_pkg::TIME_W-1:0]     now_ms,
    input  logic                           link_up,

    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [1:0]                     state_code,
    input  logic                           connect_request,
    input  logic                           disconnect_request,
    input  logic [lrb_pkg::COUNT_W-1:0]    retry_count,
    input  logic [lrb_pkg::TIME_W-1:0]     current_backoff_ms,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrb_pkg::TIME_W-1:0]     cfg_data,

    output int                             fail_count,
    output int                             pending
);

    logic [1:0]                  link_state;
    logic [lrb_pkg::TIME_W-1:0]  attempt_start;
    logic [lrb_pkg::TIME_W-1:0]  backoff_until;
    logic [lrb_pkg::TIME_W-1:0]  delay_ms;
    logic [lrb_pkg::COUNT_W-1:0] timeouts;

    logic [lrb_pkg::TIME_W-1:0]  timeout_cfg;
    logic [lrb_pkg::TIME_W-1:0]  base_cfg;
    logic [lrb_pkg::TIME_W-1:0]  max_cfg;

    lrb_pkg::result_t            expected_results[$];
    lrb_pkg::result_t            oldest;
    lrb_pkg::item_t              req;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic lrb_pkg::result_t next_link_result(input lrb_pkg::item_t r);
        logic [lrb_pkg::TIME_W:0]   doubled;
        logic [lrb_pkg::TIME_W-1:0] elapsed;
        lrb_pkg::result_t           res;
        res = '0;
        if (r.command == lrb_pkg::CMD_START)
        begin
            link_state = lrb_pkg::STATE_CONNECTING;
            attempt_start = r.now_ms;
            res.connect_request = 1'b1;
        end
        else if (link_state == lrb_pkg::STATE_CONNECTING)
        begin
            elapsed = r.now_ms - attempt_start;
            if (r.link_up)
            begin
                link_state = lrb_pkg::STATE_CONNECTED;
                delay_ms = base_cfg;
                timeouts = '0;
            end
            else if (elapsed > timeout_cfg)
            begin
                link_state = lrb_pkg::STATE_BACKOFF;
                backoff_until = r.now_ms + delay_ms;
                if (timeouts != lrb_pkg::COUNT_MAX)
                    timeouts = timeouts + 1'b1;
                doubled = {delay_ms, 1'b0};
                if (doubled > {1'b0, max_cfg})
                    doubled = {1'b0, max_cfg};
                delay_ms = doubled[lrb_pkg::TIME_W-1:0];
                res.disconnect_request = 1'b1;
            end
        end
        else if (link_state == lrb_pkg::STATE_CONNECTED)
        begin
            if (!r.link_up)
            begin
                link_state = lrb_pkg::STATE_CONNECTING;
                attempt_start = r.now_ms;
                res.connect_request = 1'b1;
            end
        end
        else if (link_state == lrb_pkg::STATE_BACKOFF)
        begin
            elapsed = r.now_ms - backoff_until;
            // The backoff has ended once the time is at or past its end by less
            // than half the wrap range.
            if (!elapsed[lrb_pkg::TIME_W-1])
            begin
                link_state = lrb_pkg::STATE_CONNECTING;
                attempt_start = r.now_ms;
                res.connect_request = 1'b1;
            end
        end
        res.state_code = link_state;
        res.retry_count = timeouts;
        res.current_backoff_ms = delay_ms;
        return res;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field_name, exp_val,
                     act_val);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_state = lrb_pkg::STATE_IDLE;
            attempt_start = '0;
            backoff_until = '0;
            delay_ms = lrb_pkg::BACKOFF_BASE_RESET;
            timeouts = '0;
            timeout_cfg = lrb_pkg::CONNECT_TIMEOUT_RESET;
            base_cfg = lrb_pkg::BACKOFF_BASE_RESET;
            max_cfg = lrb_pkg::BACKOFF_MAX_RESET;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lrb_pkg::REG_CONNECT_TIMEOUT: timeout_cfg = cfg_data;
                    lrb_pkg::REG_BACKOFF_BASE:    base_cfg = cfg_data;
                    lrb_pkg::REG_BACKOFF_MAX:     max_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result expected none actual %0h", $time,
                             {state_code, connect_request, disconnect_request,
                              retry_count, current_backoff_ms});
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("state_code", 32'(oldest.state_code), 32'(state_code));
                    check_field("connect_request", 32'(oldest.connect_request),
                                32'(connect_request));
                    check_field("disconnect_request", 32'(oldest.disconnect_request),
                                32'(disconnect_request));
                    check_field("retry_count", 32'(oldest.retry_count), 32'(retry_count));
                    check_field("current_backoff_ms", oldest.current_backoff_ms,
                                current_backoff_ms);
                end
            end
            if (in_valid && !in_stall)
            begin
                req.command = command;
                req.now_ms = now_ms;
                req.link_up = link_up;
                expected_results.push_back(next_link_result(req));
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Link reconnect backoff testbench
// Drives start and poll requests into the controller, writes its registers
// between phases, and stalls the result channel. A directed sequence walks
// the state machine through its corner cases, a short run with a zero
// timeout and delay repeats timeouts back to back, and random phases follow
// under several register settings and idling patterns. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 50_000;
    localparam logic [lrb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    logic                          in_valid;
    logic                          in_stall;
    logic                          command;
    logic [lrb_pkg::TIME_W-1:0]    now_ms;
    logic                          link_up;

    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    state_code;
    logic                          connect_request;
    logic                          disconnect_request;
    logic [lrb_pkg::COUNT_W-1:0]   retry_count;
    logic [lrb_pkg::TIME_W-1:0]    current_backoff_ms;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lrb_pkg::TIME_W-1:0]    cfg_data;

    int fail_count;
    int pending;

    logic in_fire = 1'b0;
    logic cfg_fire = 1'b0;
    int unsigned cycle_count = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    logic [lrb_pkg::TIME_W-1:0] clock_ms;
    logic                       link_hint;
    logic [lrb_pkg::TIME_W-1:0] timeout_now;
    logic [lrb_pkg::TIME_W-1:0] base_now;
    logic [lrb_pkg::TIME_W-1:0] max_now;

    link_reconnect_backoff_fsm i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .now_ms             (now_ms),
        .link_up            (link_up),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .state_code         (state_code),
        .connect_request    (connect_request),
        .disconnect_request (disconnect_request),
        .retry_count        (retry_count),
        .current_backoff_ms (current_backoff_ms),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    link_backoff_checker i_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .now_ms             (now_ms),
        .link_up            (link_up),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .state_code         (state_code),
        .connect_request    (connect_request),
        .disconnect_request (disconnect_request),
        .retry_count        (retry_count),
        .current_backoff_ms (current_backoff_ms),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        cfg_fire <= cfg_valid && cfg_ready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall = (out_stall_pct != 0) && ($urandom_range(99, 0) < out_stall_pct);
    end

    task automatic send_request(input logic cmd, input logic [lrb_pkg::TIME_W-1:0] t,
                                input logic up);
        while ($urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command = cmd;
        now_ms = t;
        link_up = up;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lrb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lrb_pkg::TIME_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid = 1'b0;
        case (idx)
            lrb_pkg::REG_CONNECT_TIMEOUT: timeout_now = value;
            lrb_pkg::REG_BACKOFF_BASE:    base_now = value;
            lrb_pkg::REG_BACKOFF_MAX:     max_now = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int set);
        logic [lrb_pkg::TIME_W-1:0] t;
        logic [lrb_pkg::TIME_W-1:0] b;
        logic [lrb_pkg::TIME_W-1:0] m;
        case (set)
            0: begin t = 32'd50;         b = 32'd1;            m = 32'd1;          end
            1: begin t = 32'hFFFF_FFFF;  b = 32'hFFFF_FFFF;    m = 32'hFFFF_FFFF;  end
            2: begin t = 32'd200;        b = 32'h9000_0000;    m = 32'hFFFF_FFFF;  end
            3: begin t = 32'd1000;       b = 32'd5000;         m = 32'd300;        end
            4: begin t = 32'd30;         b = 32'd3;            m = 32'd1000;       end
            5: begin t = 32'd0;          b = 32'd1;            m = 32'd64;         end
            default:
            begin
                t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
                b = $urandom_range(1, 500);
                m = $urandom_range(1, 5000);
            end
        endcase
        write_reg(lrb_pkg::REG_CONNECT_TIMEOUT, t);
        write_reg(lrb_pkg::REG_BACKOFF_BASE, b);
        write_reg(lrb_pkg::REG_BACKOFF_MAX, m);
    endtask

    // Most requests follow a plausible timeline with a slowly changing link;
    // the rest are arbitrary.
    task automatic random_traffic(input int count);
        logic [lrb_pkg::TIME_W-1:0] step;
        logic                       cmd;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99, 0) < 15)
            begin
                send_request(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                if ($urandom_range(99, 0) < 10)
                    link_hint = ~link_hint;
                cmd = ($urandom_range(99, 0) < 6) ? lrb_pkg::CMD_START : lrb_pkg::CMD_POLL;
                case ($urandom_range(0, 5))
                    0: step = $urandom_range(0, 3);
                    1: step = timeout_now + 32'($urandom_range(0, 2)) - 32'd1;
                    2: step = $urandom_range(0, 64);
                    3: step = base_now << $urandom_range(0, 6);
                    4: step = $urandom;
                    default: step = 32'h8000_0000 + 32'($urandom_range(0, 2)) - 32'd1;
                endcase
                clock_ms = clock_ms + step;
                send_request(cmd, clock_ms, link_hint);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = lrb_pkg::CMD_POLL;
        now_ms = '0;
        link_up = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lrb_pkg::REG_CONNECT_TIMEOUT;
        cfg_data = '0;
        clock_ms = '0;
        link_hint = 1'b0;
        timeout_now = lrb_pkg::CONNECT_TIMEOUT_RESET;
        base_now = lrb_pkg::BACKOFF_BASE_RESET;
        max_now = lrb_pkg::BACKOFF_MAX_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk through the states with the register defaults.
        send_request(lrb_pkg::CMD_POLL,  32'd0,          1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'hFFFF_FFFF,  1'b1);
        send_request(lrb_pkg::CMD_START, 32'd100,        1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd200,        1'b1);
        send_request(lrb_pkg::CMD_POLL,  32'd300,        1'b1);
        send_request(lrb_pkg::CMD_POLL,  32'd400,        1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd10400,      1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd10401,      1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd11400,      1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd11401,      1'b0);
        send_request(lrb_pkg::CMD_START, 32'd11500,      1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'd21501,      1'b1);
        send_request(lrb_pkg::CMD_START, 32'd21600,      1'b1);
        send_request(lrb_pkg::CMD_POLL,  32'hFFFF_FF00,  1'b0);
        send_request(lrb_pkg::CMD_START, 32'hFFFF_FF10,  1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'h0000_2621,  1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'h8000_2DF1,  1'b0);
        send_request(lrb_pkg::CMD_POLL,  32'h8000_2DF0,  1'b0);
        wait_drained();

        // A write to the unused index must leave everything alone.
        write_reg(REG_UNUSED, 32'h0000_0000);
        send_request(lrb_pkg::CMD_POLL,  32'h8000_5501,  1'b1);
        wait_drained();

        // With a zero timeout and a zero delay every other poll times out,
        // so the retry count climbs with each pair of polls.
        write_reg(lrb_pkg::REG_CONNECT_TIMEOUT, 32'd0);
        write_reg(lrb_pkg::REG_BACKOFF_BASE, 32'd0);
        send_request(lrb_pkg::CMD_START, clock_ms, 1'b0);
        send_request(lrb_pkg::CMD_POLL,  clock_ms, 1'b1);
        for (int i = 0; i < 24; i++)
        begin
            clock_ms = clock_ms + 32'd1;
            send_request(lrb_pkg::CMD_POLL, clock_ms, 1'b0);
        end
        send_request(lrb_pkg::CMD_START, clock_ms, 1'b0);
        send_request(lrb_pkg::CMD_POLL,  clock_ms, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 12; phase++)
        begin
            apply_setting(phase % 7);
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 84; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 84; end
                default: begin in_idle_pct = 29; out_stall_pct = 29; end
            endcase
            random_traffic(75);
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
